[hdl/cfb_pkg.sv]
// ----------------------------------------------------------------------------
// cfb_pkg
// Shared types, constants and functions of the CRC-16 data frame builder.
// ----------------------------------------------------------------------------
package cfb_pkg;

  localparam int MAX_PAYLOAD = 32;
  localparam int ADDR_W      = $clog2(MAX_PAYLOAD);
  localparam int CNT_W       = $clog2(MAX_PAYLOAD + 1);

  localparam logic [7:0]  START_BYTE = 8'h5A;
  localparam logic [15:0] CRC_POLY   = 16'h1021;
  localparam logic [15:0] CRC_TOP    = 16'h8000;

  // header byte positions
  localparam logic [2:0] HDR_START  = 3'd0;
  localparam logic [2:0] HDR_TYPE   = 3'd1;
  localparam logic [2:0] HDR_LEN_LO = 3'd2;
  localparam logic [2:0] HDR_LEN_HI = 3'd3;
  localparam logic [2:0] HDR_CRC_LO = 3'd4;
  localparam logic [2:0] HDR_CRC_HI = 3'd5;

  typedef enum logic [2:0] {
    ST_LOAD,
    ST_CRC_HDR,
    ST_CRC_PAY,
    ST_EMIT_HDR,
    ST_EMIT_PAY
  } state_t;

  typedef struct packed {
    logic load;
    logic crc_hdr;
    logic crc_pay;
    logic emit_hdr;
    logic emit_pay;
  } cmd_t;

  typedef struct packed {
    logic take_last;
    logic crc_hdr_end;
    logic emit_hdr_end;
    logic pay_end;
    logic slot_free;
  } status_t;

  function automatic logic [15:0] crc_byte(input logic [15:0] crc, input logic [7:0] b);
    logic [15:0] c;
    c = crc ^ {b, 8'h00};
    for (int k = 0; k < 8; k++) begin
      if ((c & CRC_TOP) != 16'h0000) begin
        c = {c[14:0], 1'b0} ^ CRC_POLY;
      end else begin
        c = {c[14:0], 1'b0};
      end
    end
    return c;
  endfunction

  function automatic logic [7:0] hdr_byte(input logic [2:0] sel, input logic [7:0] ptype,
                                          input logic [CNT_W-1:0] count,
                                          input logic [15:0] crc);
    logic [15:0] len;
    logic [7:0]  b;
    len = 16'(count);
    case (sel)
      HDR_START:  b = START_BYTE;
      HDR_TYPE:   b = ptype;
      HDR_LEN_LO: b = len[7:0];
      HDR_LEN_HI: b = len[15:8];
      HDR_CRC_LO: b = crc[7:0];
      HDR_CRC_HI: b = crc[15:8];
      default:    b = 8'h00;
    endcase
    return b;
  endfunction

endpackage

[hdl/cfb_in_if.sv]
// ----------------------------------------------------------------------------
// cfb_in_if
// Payload byte channel: one payload byte per transfer.
// ----------------------------------------------------------------------------
interface cfb_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] payload_byte;
  logic       is_last;
  logic [7:0] packet_type;

  modport source (output valid, output payload_byte, output is_last, output packet_type,
                  input ready);
  modport sink   (input valid, input payload_byte, input is_last, input packet_type,
                  output ready);
endinterface

[hdl/cfb_out_if.sv]
// ----------------------------------------------------------------------------
// cfb_out_if
// Frame byte channel: one frame byte per transfer.
// ----------------------------------------------------------------------------
interface cfb_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] frame_byte;
  logic       frame_end;
  logic       truncated;

  modport source (output valid, output frame_byte, output frame_end, output truncated,
                  input ready);
  modport sink   (input valid, input frame_byte, input frame_end, input truncated,
                  output ready);
endinterface

[hdl/cfb_ram.sv]
// ----------------------------------------------------------------------------
// cfb_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module cfb_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 32
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     ren,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (ren) begin
      rdata <= mem[raddr];
    end
  end

endmodule

[hdl/cfb_ctrl.sv]
// ----------------------------------------------------------------------------
// cfb_ctrl
// Sequencer: load, CRC pass over header and buffer, header and payload output.
// ----------------------------------------------------------------------------
module cfb_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  cfb_pkg::status_t  status,
  output cfb_pkg::cmd_t     cmd
);

  cfb_pkg::state_t state;
  cfb_pkg::state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= cfb_pkg::ST_LOAD;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd        = '0;
    case (state)
      cfb_pkg::ST_LOAD: begin
        cmd.load = 1'b1;
        if (status.take_last) state_next = cfb_pkg::ST_CRC_HDR;
      end
      cfb_pkg::ST_CRC_HDR: begin
        cmd.crc_hdr = 1'b1;
        if (status.crc_hdr_end) state_next = cfb_pkg::ST_CRC_PAY;
      end
      cfb_pkg::ST_CRC_PAY: begin
        cmd.crc_pay = 1'b1;
        if (status.pay_end) state_next = cfb_pkg::ST_EMIT_HDR;
      end
      cfb_pkg::ST_EMIT_HDR: begin
        cmd.emit_hdr = 1'b1;
        if (status.slot_free && status.emit_hdr_end) state_next = cfb_pkg::ST_EMIT_PAY;
      end
      cfb_pkg::ST_EMIT_PAY: begin
        cmd.emit_pay = 1'b1;
        if (status.slot_free && status.pay_end) state_next = cfb_pkg::ST_LOAD;
      end
      default: begin
        state_next = cfb_pkg::ST_LOAD;
      end
    endcase
  end

endmodule

[hdl/cfb_dp.sv]
// ----------------------------------------------------------------------------
// cfb_dp
// Datapath: payload buffer, byte count, type, CRC unit, output register.
// ----------------------------------------------------------------------------
module cfb_dp (
  input  logic              clk,
  input  logic              rst,
  input  cfb_pkg::cmd_t     cmd,
  output cfb_pkg::status_t  status,
  cfb_in_if.sink            pkt_in,
  cfb_out_if.source         frame_out
);

  localparam logic [cfb_pkg::CNT_W-1:0] CNT_FULL = cfb_pkg::CNT_W'(cfb_pkg::MAX_PAYLOAD);
  localparam logic [cfb_pkg::CNT_W-1:0] CRC_HDR_LAST = cfb_pkg::CNT_W'(cfb_pkg::HDR_LEN_HI);
  localparam logic [cfb_pkg::CNT_W-1:0] EMIT_HDR_LAST = cfb_pkg::CNT_W'(cfb_pkg::HDR_CRC_HI);

  logic [cfb_pkg::CNT_W-1:0]  count;
  logic [cfb_pkg::CNT_W-1:0]  idx;
  logic [cfb_pkg::CNT_W-1:0]  idx_plus;
  logic [7:0]                 type_hold;
  logic                       ovf;
  logic [15:0]                crc;
  logic                       ovalid;
  logic [7:0]                 obyte;
  logic                       oend;
  logic                       otrunc;

  logic                       accept;
  logic                       full;
  logic                       slot_free;
  logic                       load_out;
  logic [7:0]                 hdr_b;
  logic [7:0]                 rdata;
  logic                       ren;
  logic [cfb_pkg::ADDR_W-1:0] raddr;

  cfb_ram #(
    .WIDTH (8),
    .DEPTH (cfb_pkg::MAX_PAYLOAD)
  ) u_ram (
    .clk   (clk),
    .we    (accept && !full),
    .waddr (count[cfb_pkg::ADDR_W-1:0]),
    .wdata (pkt_in.payload_byte),
    .ren   (ren),
    .raddr (raddr),
    .rdata (rdata)
  );

  always_comb begin
    pkt_in.ready = cmd.load;
    accept    = pkt_in.valid && cmd.load;
    full      = (count == CNT_FULL);
    idx_plus  = idx + 1'b1;
    slot_free = !ovalid || frame_out.ready;
    hdr_b     = cfb_pkg::hdr_byte(idx[2:0], type_hold, count, crc);
    load_out  = slot_free && (cmd.emit_hdr || cmd.emit_pay);

    ren   = 1'b0;
    raddr = '0;
    if (cmd.crc_hdr || cmd.emit_hdr) begin
      ren = 1'b1;
    end else if (cmd.crc_pay) begin
      ren   = 1'b1;
      raddr = idx_plus[cfb_pkg::ADDR_W-1:0];
    end else if (cmd.emit_pay) begin
      ren   = slot_free;
      raddr = idx_plus[cfb_pkg::ADDR_W-1:0];
    end

    status.take_last    = accept && pkt_in.is_last;
    status.crc_hdr_end  = (idx == CRC_HDR_LAST);
    status.emit_hdr_end = (idx == EMIT_HDR_LAST);
    status.pay_end      = (idx == count - 1'b1);
    status.slot_free    = slot_free;

    frame_out.valid      = ovalid;
    frame_out.frame_byte = obyte;
    frame_out.frame_end  = oend;
    frame_out.truncated  = otrunc;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count     <= '0;
      idx       <= '0;
      type_hold <= '0;
      ovf       <= 1'b0;
      crc       <= '0;
      ovalid    <= 1'b0;
    end else begin
      if (accept) begin
        if (count == '0 && !ovf) type_hold <= pkt_in.packet_type;
        if (full) begin
          ovf <= 1'b1;
        end else begin
          count <= count + 1'b1;
        end
        idx <= '0;
        if (pkt_in.is_last) crc <= '0;
      end

      if (cmd.crc_hdr) begin
        crc <= cfb_pkg::crc_byte(crc, hdr_b);
        idx <= status.crc_hdr_end ? '0 : idx_plus;
      end

      if (cmd.crc_pay) begin
        crc <= cfb_pkg::crc_byte(crc, rdata);
        idx <= status.pay_end ? '0 : idx_plus;
      end

      if (cmd.emit_hdr && slot_free) begin
        idx <= status.emit_hdr_end ? '0 : idx_plus;
      end

      if (cmd.emit_pay && slot_free) begin
        if (status.pay_end) begin
          idx   <= '0;
          count <= '0;
          ovf   <= 1'b0;
        end else begin
          idx <= idx_plus;
        end
      end

      if (load_out) begin
        ovalid <= 1'b1;
      end else if (frame_out.ready) begin
        ovalid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load_out) begin
      obyte  <= cmd.emit_hdr ? hdr_b : rdata;
      oend   <= cmd.emit_pay && status.pay_end;
      otrunc <= ovf;
    end
  end

endmodule

[hdl/crc16_data_frame_builder.sv]
// ----------------------------------------------------------------------------
// crc16_data_frame_builder
// Buffers payload bytes and sends them as a framed packet with CRC-16/XMODEM.
// ----------------------------------------------------------------------------
// pkt_in carries one payload byte per transfer with is_last and packet_type;
// the type is taken with the first byte of a packet. Up to 32 bytes are
// buffered; later bytes are dropped and the frame is flagged truncated.
// Bytes are taken one per cycle while loading. After the transfer marked
// last, the block stops taking bytes, runs the CRC over the 4 header bytes
// and the n buffered bytes (one byte per cycle through the buffer RAM read
// port), then sends 6 header bytes (0x5A, type, length low/high, CRC
// low/high) and the n payload bytes on frame_out, one per cycle while the
// receiver is ready.
// frame_out is held in an output register: when the receiver stalls, the
// current byte holds and the sequence pauses. Loading of the next packet
// starts as soon as the last frame byte sits in the output register.
// Reset (rst, synchronous) returns to loading with an empty buffer.
// ----------------------------------------------------------------------------
module crc16_data_frame_builder (
  input  logic      clk,
  input  logic      rst,
  cfb_in_if.sink    pkt_in,
  cfb_out_if.source frame_out
);

  cfb_pkg::cmd_t    cmd;
  cfb_pkg::status_t status;

  cfb_ctrl u_ctrl (
    .clk    (clk),
    .rst    (rst),
    .status (status),
    .cmd    (cmd)
  );

  cfb_dp u_dp (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd),
    .status    (status),
    .pkt_in    (pkt_in),
    .frame_out (frame_out)
  );

endmodule
